// ----- rtl/priority_stack_lifo_ties_core_macros.svh -----
// assertion macros shared by the priority stack rtl
`ifndef PRIORITY_STACK_LIFO_TIES_CORE_MACROS_SVH
`define PRIORITY_STACK_LIFO_TIES_CORE_MACROS_SVH

// checked only while out of reset
`define PSLT_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge
`define PSLT_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pslt_pkg.sv -----
// types and constants of the priority stack
package pslt_pkg;

  localparam int CAPACITY       = 16;
  localparam int DATA_WIDTH     = 32;
  localparam int PRIORITY_WIDTH = 8;
  localparam int CNT_W          = $clog2(CAPACITY + 1);

  localparam int ACTION_W = 2;
  localparam int IN_PRIO_W = 8;
  localparam int IN_DATA_W = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_POP_EMPTY  = 2'd1,
    STAT_PUSH_FULL  = 2'd2
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    logic                      push;
    logic                      pop;
    logic [PRIORITY_WIDTH-1:0] new_prio;
    logic [DATA_WIDTH-1:0]     new_data;
  } cell_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                      ge;
    logic [PRIORITY_WIDTH-1:0] prio;
    logic [DATA_WIDTH-1:0]     data;
  } cell_link_t;

endpackage

// ----- rtl/pslt_if.sv -----
// valid/ready channel interfaces of the priority stack
interface pslt_in_if;
  logic                           valid;
  logic                           ready;
  logic [pslt_pkg::ACTION_W-1:0]  action;
  logic [pslt_pkg::IN_PRIO_W-1:0] priority_in;
  logic [pslt_pkg::IN_DATA_W-1:0] data_in;

  modport source (output valid, action, priority_in, data_in, input ready);
  modport sink   (input valid, action, priority_in, data_in, output ready);
endinterface

interface pslt_out_if;
  logic                           valid;
  logic                           ready;
  logic [pslt_pkg::IN_DATA_W-1:0] data_out;
  logic [pslt_pkg::IN_PRIO_W-1:0] priority_out;
  logic                           popped;
  logic [pslt_pkg::STATUS_W-1:0]  status;
  logic                           is_empty;
  logic                           is_full;

  modport source (output valid, data_out, priority_out, popped, status, is_empty, is_full,
                  input ready);
  modport sink   (input valid, data_out, priority_out, popped, status, is_empty, is_full,
                  output ready);
endinterface

// ----- rtl/pslt_cell.sv -----
// one slot of the sorted shift chain
module pslt_cell (
  input  logic                 clk,
  input  pslt_pkg::cell_ctl_t  ctl,
  input  logic                 valid,
  input  pslt_pkg::cell_link_t left,
  input  pslt_pkg::cell_link_t right,
  output pslt_pkg::cell_link_t link
);

  logic [pslt_pkg::PRIORITY_WIDTH-1:0] prio_r, prio_nxt;
  logic [pslt_pkg::DATA_WIDTH-1:0]     data_r, data_nxt;
  logic                                ge;

  // strictly higher entries stay ahead of a new push
  assign ge = valid && (prio_r > ctl.new_prio);

  assign link.ge   = ge;
  assign link.prio = prio_r;
  assign link.data = data_r;

  always_comb begin
    prio_nxt = prio_r;
    data_nxt = data_r;
    priority if (ctl.push) begin
      if (!ge) begin
        if (left.ge) begin
          prio_nxt = ctl.new_prio;
          data_nxt = ctl.new_data;
        end else begin
          prio_nxt = left.prio;
          data_nxt = left.data;
        end
      end
    end else if (ctl.pop) begin
      prio_nxt = right.prio;
      data_nxt = right.data;
    end else begin
      prio_nxt = prio_r;
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    data_r <= data_nxt;
  end

endmodule

// ----- rtl/priority_stack_lifo_ties_core.sv -----
// Bounded priority stack: entries sit in a chain of CAPACITY cells kept sorted by priority,
// highest first and newest first among equal priorities, so a pop always takes the head
// cell and a push slides lower entries one cell down. The
// chain updates in the cycle the beat is accepted and the result lands in an output
// register, so one beat per cycle is sustained while the result side keeps up. A push on
// a full stack is dropped and flagged, a pop on an empty stack returns zeros and is flagged.
`include "priority_stack_lifo_ties_core_macros.svh"

module priority_stack_lifo_ties_core (
  input  logic         clk,
  input  logic         rst_n,
  pslt_in_if.sink      in_chan,
  pslt_out_if.source   out_chan
);

  localparam int CAP = pslt_pkg::CAPACITY;

  logic [pslt_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       out_valid_r;
  logic [pslt_pkg::IN_DATA_W-1:0] data_out_r, data_out_nxt;
  logic [pslt_pkg::IN_PRIO_W-1:0] prio_out_r, prio_out_nxt;
  logic                       popped_r, popped_nxt;
  pslt_pkg::status_t          status_r, status_nxt;
  logic                       is_empty_r, is_full_r;

  logic                 acc, full, empty, do_push, do_pop, do_clear;
  pslt_pkg::action_t    act;
  pslt_pkg::cell_ctl_t  ctl;
  pslt_pkg::cell_link_t links [CAP];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign acc   = in_chan.valid && in_chan.ready;
  assign act   = pslt_pkg::action_t'(in_chan.action);
  assign full  = (count_r == pslt_pkg::CNT_W'(CAP));
  assign empty = (count_r == '0);

  always_comb begin
    do_push      = 1'b0;
    do_pop       = 1'b0;
    do_clear     = 1'b0;
    status_nxt   = pslt_pkg::STAT_OK;
    unique case (act)
      pslt_pkg::ACT_PUSH: begin
        do_push = acc && !full;
        if (full) status_nxt = pslt_pkg::STAT_PUSH_FULL;
      end
      pslt_pkg::ACT_POP: begin
        do_pop = acc && !empty;
        if (empty) status_nxt = pslt_pkg::STAT_POP_EMPTY;
      end
      pslt_pkg::ACT_CLEAR: do_clear = acc;
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    priority if (do_clear) count_nxt = '0;
    else if (do_push)      count_nxt = count_r + pslt_pkg::CNT_W'(1);
    else if (do_pop)       count_nxt = count_r - pslt_pkg::CNT_W'(1);
    else                   count_nxt = count_r;
  end

  always_comb begin
    data_out_nxt = '0;
    prio_out_nxt = '0;
    popped_nxt   = 1'b0;
    if (do_pop) begin
      data_out_nxt = pslt_pkg::IN_DATA_W'(links[0].data);
      prio_out_nxt = pslt_pkg::IN_PRIO_W'(links[0].prio);
      popped_nxt   = 1'b1;
    end
  end

  assign ctl.push     = do_push;
  assign ctl.pop      = do_pop;
  assign ctl.new_prio = pslt_pkg::PRIORITY_WIDTH'(in_chan.priority_in);
  assign ctl.new_data = pslt_pkg::DATA_WIDTH'(in_chan.data_in);

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    pslt_pkg::cell_link_t left_l, right_l;
    logic                 valid_l;

    if (g == 0) begin : g_head
      assign left_l = '{ge: 1'b1, prio: '0, data: '0};
    end else begin : g_mid
      assign left_l = links[g-1];
    end
    if (g == CAP - 1) begin : g_tail
      assign right_l = '0;
    end else begin : g_body
      assign right_l = links[g+1];
    end
    assign valid_l = (pslt_pkg::CNT_W'(g) < count_r);

    pslt_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .valid (valid_l),
      .left  (left_l),
      .right (right_l),
      .link  (links[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      data_out_r <= data_out_nxt;
      prio_out_r <= prio_out_nxt;
      popped_r   <= popped_nxt;
      status_r   <= status_nxt;
      is_empty_r <= (count_nxt == '0);
      is_full_r  <= (count_nxt == pslt_pkg::CNT_W'(CAP));
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.data_out     = data_out_r;
  assign out_chan.priority_out = prio_out_r;
  assign out_chan.popped       = popped_r;
  assign out_chan.status       = status_r;
  assign out_chan.is_empty     = is_empty_r;
  assign out_chan.is_full      = is_full_r;

  `PSLT_ASSERT_RST(a_count_range, clk, rst_n,
    count_r <= pslt_pkg::CNT_W'(CAP), "count over capacity")
  `PSLT_ASSERT_RST(a_head_sorted, clk, rst_n,
    (count_r >= pslt_pkg::CNT_W'(2)) |-> (links[0].prio >= links[1].prio), "head not highest")
  `PSLT_ASSERT_RST(a_pop_count, clk, rst_n,
    do_pop |=> (count_r == $past(count_r) - pslt_pkg::CNT_W'(1)), "pop count slip")
  `PSLT_ASSERT_RST(a_popped_ok, clk, rst_n,
    (out_valid_r && popped_r) |-> (status_r == pslt_pkg::STAT_OK), "popped with error status")
  `PSLT_ASSERT(a_reset_idle, clk,
    !$past(rst_n) |-> (!out_valid_r && count_r == '0), "not idle after reset")

endmodule
